@@ rtl/orol_pkg.sv @@
`timescale 1ns / 1ps
// shared types, sizes and helpers for the overwrite ring offset lookup unit
// no dependencies
package orol_pkg;

    localparam int DEPTH     = 16;
    localparam int SIZE_BITS = 16;

    localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int BASE_W = SIZE_BITS + IDX_W + 1;
    localparam int OFF_W  = 20;
    localparam int CMP_W  = ((BASE_W > OFF_W) ? BASE_W : OFF_W) + 1;
    localparam int HDL_W  = 32;
    localparam int ENT_W  = HDL_W + SIZE_BITS;

    localparam logic REQ_ADD  = 1'b0;
    localparam logic REQ_FIND = 1'b1;

    typedef logic [IDX_W-1:0]     t_idx;
    typedef logic [CNT_W-1:0]     t_cnt;
    typedef logic [BASE_W-1:0]    t_base;
    typedef logic [SIZE_BITS-1:0] t_size;

    typedef struct packed {
        logic        req_type;
        logic [31:0] new_handle;
        logic [15:0] new_size;
        logic [19:0] byte_offset;
    } t_req;

    typedef struct packed {
        logic        evicted;
        logic [31:0] evicted_handle;
        logic        found;
        logic [31:0] hit_handle;
        logic [15:0] hit_size;
        logic [15:0] offset_in_entry;
    } t_rsp;

    function automatic t_idx next_idx(input t_idx i);
        return (i == IDX_W'(DEPTH - 1)) ? '0 : (i + t_idx'(1));
    endfunction

endpackage

@@ rtl/orol_ram.sv @@
`timescale 1ns / 1ps
// generic single write port, single read port ram with registered read
// no dependencies
module orol_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ rtl/overwrite_ring_offset_lookup_unit.sv @@
`timescale 1ns / 1ps
// an add goes through S_ADD and S_DONE to the result register; a find goes through S_FIND,
// where it walks k (1..DEPTH) entries, one ram read per cycle, and then S_DONE; an empty ring
// goes straight from acceptance to S_DONE. one request is in work at a time: the next is
// accepted once the unit is back in S_IDLE; the result register lets it in while a result
// waits. synchronous active-low reset empties the ring, not the ram.
// top level of the overwrite ring offset lookup unit, uses orol_pkg and orol_ram
module overwrite_ring_offset_lookup_unit
    import orol_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_req_valid,
    output logic o_req_ready,
    input  t_req i_req,
    output logic o_rsp_valid,
    input  logic i_rsp_ready,
    output t_rsp o_rsp
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_ADD,
        S_FIND,
        S_DONE
    } t_state;

    t_state r_state, n_state;
    t_idx   r_wr_idx, n_wr_idx;
    t_idx   r_rd_idx, n_rd_idx;
    logic   r_full, n_full;
    t_req   r_req, n_req;
    t_idx   r_idx, n_idx;
    t_cnt   r_left, n_left;
    t_base  r_base, n_base;
    t_rsp   r_res, n_res;
    logic   r_out_valid, n_out_valid;
    t_rsp   r_out, n_out;

    logic             ram_wr_en;
    t_idx             ram_wr_addr;
    logic [ENT_W-1:0] ram_wr_data;
    logic             ram_rd_en;
    t_idx             ram_rd_addr;
    logic [ENT_W-1:0] ram_rd_data;

    logic [HDL_W-1:0] rd_handle;
    t_size            rd_size;
    t_cnt             count;
    logic             accept;
    logic [CMP_W-1:0] span_end;
    logic [CMP_W-1:0] off_ext;
    logic [CMP_W-1:0] off_diff;
    t_idx             rd_nxt;
    t_idx             wr_nxt;

    orol_ram #(
        .WIDTH (ENT_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (ram_wr_en),
        .i_wr_addr (ram_wr_addr),
        .i_wr_data (ram_wr_data),
        .i_rd_en   (ram_rd_en),
        .i_rd_addr (ram_rd_addr),
        .o_rd_data (ram_rd_data)
    );

    assign rd_handle = ram_rd_data[ENT_W-1:SIZE_BITS];
    assign rd_size   = ram_rd_data[SIZE_BITS-1:0];

    assign o_req_ready = (r_state == S_IDLE);
    assign accept      = i_req_valid && o_req_ready;

    assign count = r_full ? CNT_W'(DEPTH) :
                   (r_wr_idx >= r_rd_idx) ? (CNT_W'(r_wr_idx) - CNT_W'(r_rd_idx)) :
                   (CNT_W'(DEPTH) - (CNT_W'(r_rd_idx) - CNT_W'(r_wr_idx)));

    assign span_end = CMP_W'(r_base) + CMP_W'(rd_size);
    assign off_ext  = CMP_W'(r_req.byte_offset);
    assign off_diff = off_ext - CMP_W'(r_base);

    always_comb begin
        n_state     = r_state;
        n_wr_idx    = r_wr_idx;
        n_rd_idx    = r_rd_idx;
        n_full      = r_full;
        n_req       = r_req;
        n_idx       = r_idx;
        n_left      = r_left;
        n_base      = r_base;
        n_res       = r_res;
        n_out_valid = r_out_valid;
        n_out       = r_out;
        ram_wr_en   = 1'b0;
        ram_wr_addr = r_wr_idx;
        ram_wr_data = {r_req.new_handle, SIZE_BITS'(r_req.new_size)};
        ram_rd_en   = 1'b0;
        ram_rd_addr = r_rd_idx;
        rd_nxt      = r_rd_idx;
        wr_nxt      = next_idx(r_wr_idx);

        if (r_out_valid && i_rsp_ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_req = i_req;
                    n_res = '0;
                    if (i_req.req_type == REQ_ADD) begin
                        ram_rd_en = 1'b1;
                        n_state   = S_ADD;
                    end else begin
                        n_base = '0;
                        n_idx  = r_rd_idx;
                        n_left = count;
                        if (count == '0) begin
                            n_state = S_DONE;
                        end else begin
                            ram_rd_en = 1'b1;
                            n_state   = S_FIND;
                        end
                    end
                end
            end
            S_ADD: begin
                ram_wr_en = 1'b1;
                n_res     = '0;
                if (r_full) begin
                    n_res.evicted        = 1'b1;
                    n_res.evicted_handle = rd_handle;
                    rd_nxt               = next_idx(r_rd_idx);
                end
                n_rd_idx = rd_nxt;
                n_wr_idx = wr_nxt;
                n_full   = (wr_nxt == rd_nxt);
                n_state  = S_DONE;
            end
            S_FIND: begin
                if (off_ext < span_end) begin
                    n_res.found           = 1'b1;
                    n_res.hit_handle      = rd_handle;
                    n_res.hit_size        = 16'(rd_size);
                    n_res.offset_in_entry = off_diff[15:0];
                    n_state               = S_DONE;
                end else begin
                    n_base = BASE_W'(span_end);
                    if (r_left == CNT_W'(1)) begin
                        n_state = S_DONE;
                    end else begin
                        n_left      = r_left - CNT_W'(1);
                        n_idx       = next_idx(r_idx);
                        ram_rd_addr = next_idx(r_idx);
                        ram_rd_en   = 1'b1;
                    end
                end
            end
            S_DONE: begin
                if (!r_out_valid || i_rsp_ready) begin
                    n_out       = r_res;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_wr_idx    <= '0;
            r_rd_idx    <= '0;
            r_full      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_wr_idx    <= n_wr_idx;
            r_rd_idx    <= n_rd_idx;
            r_full      <= n_full;
            r_out_valid <= n_out_valid;
        end
        r_req  <= n_req;
        r_idx  <= n_idx;
        r_left <= n_left;
        r_base <= n_base;
        r_res  <= n_res;
        r_out  <= n_out;
    end

    assign o_rsp_valid = r_out_valid;
    assign o_rsp       = r_out;

endmodule

@@ rtl/orol_checker.sv @@
`timescale 1ns / 1ps
// port-level checks for the overwrite ring offset lookup unit
// uses orol_pkg, bound to the top level below
module orol_checker
    import orol_pkg::*;
(
    input logic i_clk,
    input logic i_rst_n,
    input logic i_req_valid,
    input logic o_req_ready,
    input t_req i_req,
    input logic o_rsp_valid,
    input logic i_rsp_ready,
    input t_rsp o_rsp
);

    // result held until taken
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid && !i_rsp_ready |=> o_rsp_valid && $stable(o_rsp))
        else $error("result dropped or changed while stalled");

    // a result is either an add or a find, never both
    a_rsp_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid |-> !(o_rsp.evicted && o_rsp.found))
        else $error("result reports both eviction and hit");

    // unused fields are zero
    a_rsp_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid |-> (o_rsp.evicted || o_rsp.evicted_handle == '0) &&
                        (o_rsp.found || (o_rsp.hit_handle == '0 && o_rsp.hit_size == '0 &&
                                         o_rsp.offset_in_entry == '0)))
        else $error("result carries stale fields");

    // after reset the unit is idle and has no result pending
    a_rst_idle: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> o_req_ready && !o_rsp_valid)
        else $error("unit not idle after reset");

endmodule

bind overwrite_ring_offset_lookup_unit orol_checker u_orol_checker (.*);
